FILE: design/rlpe_pkg.sv
package rlpe_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_ONE_HIGH  = 3'd0;
    localparam logic [2:0] REG_ONE_LOW   = 3'd1;
    localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
    localparam logic [2:0] REG_ZERO_LOW  = 3'd3;
    localparam logic [2:0] REG_LATCH     = 3'd4;

    localparam int CFG_ADDR_W = 3;
    localparam int LEN_W      = 16;
    localparam int PIX_W      = 24;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    // register values after reset
    localparam logic [LEN_W-1:0] ONE_HIGH_RST  = 16'd53;
    localparam logic [LEN_W-1:0] ONE_LOW_RST   = 16'd27;
    localparam logic [LEN_W-1:0] ZERO_HIGH_RST = 16'd25;
    localparam logic [LEN_W-1:0] ZERO_LOW_RST  = 16'd56;
    localparam logic [LEN_W-1:0] LATCH_RST     = 16'd10000;

    // 24 bit segment pairs plus one latch segment
    localparam int SEGS_PER_PIXEL = 49;
    localparam int SEG_CNT_W      = $clog2(SEGS_PER_PIXEL);
    localparam logic [SEG_CNT_W-1:0] LATCH_SEG = SEG_CNT_W'(SEGS_PER_PIXEL - 1);

    // pixel queue depth, valid range 2 to 32
    localparam int QUEUE_DEPTH_DEF = 2;

    // head of the pixel queue, in transmit order (green, red, blue, msb first)
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] grb;
    } px_t;

endpackage

FILE: design/rlpe_front.sv
module rlpe_front #(
    parameter int QUEUE_DEPTH = rlpe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rlpe_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                           pop,
    output rlpe_pkg::px_t                  px
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [rlpe_pkg::PIX_W-1:0] queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic [rlpe_pkg::PIX_W-1:0] grb;

    // reorder the pixel into transmit order
    assign grb = {s_tdata[15:8], s_tdata[7:0], s_tdata[23:16]};

    assign s_tready = (count_reg != CNT_FULL);
    assign push     = s_tvalid && s_tready;

    assign px.valid = (count_reg != '0);
    assign px.grb   = queue_reg[rd_ptr_reg];

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= grb;
        end
    end

endmodule

FILE: design/rlpe_back.sv
module rlpe_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rlpe_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rlpe_pkg::LEN_W-1:0]      cfg_wdata,
    input  rlpe_pkg::px_t                   px,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rlpe_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                            m_tlast
);

    logic [rlpe_pkg::LEN_W-1:0] one_high_reg, one_low_reg, zero_high_reg, zero_low_reg;
    logic [rlpe_pkg::LEN_W-1:0] latch_reg;

    logic                              busy_reg, busy_next;
    logic [rlpe_pkg::SEG_CNT_W-1:0]    seg_cnt_reg, seg_cnt_next;
    logic [rlpe_pkg::PIX_W-1:0]        word_reg, word_next;
    logic                              valid_reg, valid_next;
    logic                              level_reg, level_next;
    logic [rlpe_pkg::LEN_W-1:0]        len_reg, len_next;
    logic                              last_reg, last_next;
    logic                              out_adv;
    logic                              bit_val;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            one_high_reg  <= rlpe_pkg::ONE_HIGH_RST;
            one_low_reg   <= rlpe_pkg::ONE_LOW_RST;
            zero_high_reg <= rlpe_pkg::ZERO_HIGH_RST;
            zero_low_reg  <= rlpe_pkg::ZERO_LOW_RST;
            latch_reg     <= rlpe_pkg::LATCH_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                rlpe_pkg::REG_ONE_HIGH:  one_high_reg  <= cfg_wdata;
                rlpe_pkg::REG_ONE_LOW:   one_low_reg   <= cfg_wdata;
                rlpe_pkg::REG_ZERO_HIGH: zero_high_reg <= cfg_wdata;
                rlpe_pkg::REG_ZERO_LOW:  zero_low_reg  <= cfg_wdata;
                rlpe_pkg::REG_LATCH:     latch_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_adv = !valid_reg || m_tready;
    assign bit_val = word_reg[rlpe_pkg::PIX_W-1];

    // segment sequencer, one segment per cycle into the output register while it can advance
    always_comb begin
        busy_next    = busy_reg;
        seg_cnt_next = seg_cnt_reg;
        word_next    = word_reg;
        valid_next   = valid_reg;
        level_next   = level_reg;
        len_next     = len_reg;
        last_next    = last_reg;
        pop          = 1'b0;
        if (busy_reg) begin
            if (out_adv) begin
                valid_next = 1'b1;
                if (seg_cnt_reg == rlpe_pkg::LATCH_SEG) begin
                    level_next   = 1'b0;
                    len_next     = latch_reg;
                    last_next    = 1'b1;
                    // take the next pixel straight away
                    pop          = px.valid;
                    busy_next    = px.valid;
                    word_next    = px.grb;
                    seg_cnt_next = '0;
                end else begin
                    last_next    = 1'b0;
                    seg_cnt_next = seg_cnt_reg + 1'b1;
                    if (!seg_cnt_reg[0]) begin
                        level_next = 1'b1;
                        len_next   = bit_val ? one_high_reg : zero_high_reg;
                    end else begin
                        level_next = 1'b0;
                        len_next   = bit_val ? one_low_reg : zero_low_reg;
                        word_next  = {word_reg[rlpe_pkg::PIX_W-2:0], 1'b0};
                    end
                end
            end
        end else begin
            if (out_adv) begin
                valid_next = 1'b0;
            end
            if (px.valid) begin
                pop          = 1'b1;
                busy_next    = 1'b1;
                word_next    = px.grb;
                seg_cnt_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            valid_reg   <= 1'b0;
            seg_cnt_reg <= '0;
        end else begin
            busy_reg    <= busy_next;
            valid_reg   <= valid_next;
            seg_cnt_reg <= seg_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        word_reg  <= word_next;
        level_reg <= level_next;
        len_reg   <= len_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(rlpe_pkg::OUT_DATA_W - rlpe_pkg::LEN_W - 1)'(0), len_reg, level_reg};
    assign m_tlast  = last_reg;

endmodule

FILE: design/rgb_led_pulse_encoder.sv
// RGB LED pulse encoder. Each input transaction carries one pixel; the block
// sends it green, red, blue, msb first, as 49 output transactions: a high and
// a low segment per data bit, lengths from the one/zero length registers,
// then one low latch segment flagged by m_tlast. The segment sequencer emits
// one segment per cycle while m_tready stays high, and a queued pixel follows
// the previous one with no gap; a pixel accepted into an idle block is loaded
// from the queue into the sequencer before its first segment is output. A
// queue of QUEUE_DEPTH pixels (2 to 32) lets the input side run ahead of the
// output. Registers reset to 53, 27, 25, 56 and 10000 delay units; write them
// only while no pixel is in flight. Writes to an index beyond 4 are ignored.
module rgb_led_pulse_encoder #(
    parameter int QUEUE_DEPTH = rlpe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [rlpe_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rlpe_pkg::LEN_W-1:0]      cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rlpe_pkg::IN_DATA_W-1:0]  s_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rlpe_pkg::OUT_DATA_W-1:0] m_tdata,  // line_level[0], seg_length[16:1], pad
    output logic                            m_tlast
);

    rlpe_pkg::px_t px;
    logic          pop;

    // input side: pixel queue
    rlpe_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .pop      (pop),
        .px       (px)
    );

    // output side: segment sequencer and registers
    rlpe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .px        (px),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // a pixel leaves the queue only when one is there
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> px.valid)
        else $error("pixel popped from empty queue");

    // the latch segment is always low
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> !m_tdata[0])
        else $error("latch segment driven high");

    // no output transaction right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // pad bits of the output stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[rlpe_pkg::OUT_DATA_W-1:rlpe_pkg::LEN_W+1] == '0))
        else $error("output pad bits not zero");

endmodule

FILE: bench/tb_rgb_led_pulse_encoder.sv
`timescale 1ns / 1ps

module tb_rgb_led_pulse_encoder;

    // register indexes past the last register, writes there must be ignored
    localparam logic [rlpe_pkg::CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [rlpe_pkg::CFG_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam logic [rlpe_pkg::LEN_W-1:0] LEN_ZERO = 16'd0;
    localparam logic [rlpe_pkg::LEN_W-1:0] LEN_MIN  = 16'd1;
    localparam logic [rlpe_pkg::LEN_W-1:0] LEN_MAX  = 16'hFFFF;

    localparam int QUIET_LIMIT    = 2000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int PHASES         = 4;
    localparam int PIXELS_PER_PHASE = 45;
    localparam int TAIL_CYCLES    = 60;

    typedef enum logic [1:0] {
        ROW_PIXEL,
        ROW_PIXEL_KNOWN,
        ROW_REG_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [rlpe_pkg::CFG_ADDR_W-1:0] addr;
        logic [rlpe_pkg::LEN_W-1:0]      value;
        logic [7:0]                      red;
        logic [7:0]                      green;
        logic [7:0]                      blue;
        logic [rlpe_pkg::LEN_W-1:0]      exp_high;
        logic [rlpe_pkg::LEN_W-1:0]      exp_low;
        logic [rlpe_pkg::LEN_W-1:0]      exp_latch;
    } stim_row_t;

    typedef struct packed {
        logic                       level;
        logic [rlpe_pkg::LEN_W-1:0] len;
        logic                       last;
    } segment_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [rlpe_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [rlpe_pkg::LEN_W-1:0]      cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [rlpe_pkg::IN_DATA_W-1:0]  s_tdata = '0;    // red[7:0], green[15:8], blue[23:16]
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [rlpe_pkg::OUT_DATA_W-1:0] m_tdata;         // line_level[0], seg_length[16:1], pad
    logic                            m_tlast;

    segment_t                   pending_segs[$];
    segment_t                   want;
    logic [rlpe_pkg::LEN_W-1:0] len_reg [5];
    stim_row_t                  directed_rows[$];
    int                         fail_cnt = 0;
    int                         quiet_cycles = 0;
    int                         hold_left = 0;
    bit                         rx_hold_req = 1'b0;
    bit                         calm = 1'b0;

    rgb_led_pulse_encoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // table row builders
    function automatic stim_row_t px(input logic [7:0] red, green, blue);
        stim_row_t row;
        row = '0;
        row.kind = ROW_PIXEL;
        row.red = red;
        row.green = green;
        row.blue = blue;
        return row;
    endfunction

    // uniform pixel (all bits equal): every bit pair has the same lengths
    function automatic stim_row_t px_known(input logic [7:0] red, green, blue,
                                           input logic [rlpe_pkg::LEN_W-1:0] hi, lo, latch);
        stim_row_t row;
        row = px(red, green, blue);
        row.kind = ROW_PIXEL_KNOWN;
        row.exp_high = hi;
        row.exp_low = lo;
        row.exp_latch = latch;
        return row;
    endfunction

    function automatic stim_row_t wr(input logic [rlpe_pkg::CFG_ADDR_W-1:0] addr,
                                     input logic [rlpe_pkg::LEN_W-1:0] value);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG_WRITE;
        row.addr = addr;
        row.value = value;
        return row;
    endfunction

    // expected segments for a pixel whose bits are all equal
    function automatic void expect_uniform(input logic [rlpe_pkg::LEN_W-1:0] hi, lo, latch);
        int b;
        for (b = 0; b < rlpe_pkg::PIX_W; b++) begin
            pending_segs.push_back(segment_t'{1'b1, hi, 1'b0});
            pending_segs.push_back(segment_t'{1'b0, lo, 1'b0});
        end
        pending_segs.push_back(segment_t'{1'b0, latch, 1'b1});
    endfunction

    // green, red, blue, msb first; a bit pair per data bit, then the latch
    function automatic void encode_pixel(input logic [7:0] red, green, blue);
        logic [rlpe_pkg::PIX_W-1:0] grb;
        int                         b;
        grb = {green, red, blue};
        for (b = rlpe_pkg::PIX_W - 1; b >= 0; b--) begin
            if (grb[b]) begin
                pending_segs.push_back(
                    segment_t'{1'b1, len_reg[rlpe_pkg::REG_ONE_HIGH], 1'b0});
                pending_segs.push_back(
                    segment_t'{1'b0, len_reg[rlpe_pkg::REG_ONE_LOW], 1'b0});
            end else begin
                pending_segs.push_back(
                    segment_t'{1'b1, len_reg[rlpe_pkg::REG_ZERO_HIGH], 1'b0});
                pending_segs.push_back(
                    segment_t'{1'b0, len_reg[rlpe_pkg::REG_ZERO_LOW], 1'b0});
            end
        end
        pending_segs.push_back(segment_t'{1'b0, len_reg[rlpe_pkg::REG_LATCH], 1'b1});
    endfunction

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [rlpe_pkg::LEN_W-1:0] rand_len();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return LEN_ZERO;
        if (pick == 1) return LEN_MIN;
        if (pick == 2) return LEN_MAX;
        return rlpe_pkg::LEN_W'($urandom_range(1, 65535));
    endfunction

    // offer one pixel until it is taken, then record what it must produce
    task automatic send_pixel(input stim_row_t row);
        s_tvalid <= 1'b1;
        s_tdata <= {row.blue, row.green, row.red};
        do @(posedge aclk); while (!s_tready);
        if (row.kind == ROW_PIXEL_KNOWN)
            expect_uniform(row.exp_high, row.exp_low, row.exp_latch);
        else
            encode_pixel(row.red, row.green, row.blue);
    endtask

    // random sender gap, noise on tdata while tvalid is low
    task automatic sender_gap();
        if (!calm && $urandom_range(99) < 25) begin
            s_tvalid <= 1'b0;
            s_tdata <= rlpe_pkg::IN_DATA_W'($urandom);
            repeat ($urandom_range(1, 25)) @(posedge aclk);
        end
    endtask

    // stop offering and wait until every expected segment has arrived
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_segs.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [rlpe_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [rlpe_pkg::LEN_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (addr <= rlpe_pkg::REG_LATCH) len_reg[addr] = value;
        @(posedge aclk);
    endtask

    task automatic randomize_regs();
        logic [rlpe_pkg::CFG_ADDR_W-1:0] addr;
        for (addr = rlpe_pkg::REG_ONE_HIGH; addr <= rlpe_pkg::REG_LATCH; addr++)
            write_reg(addr, rand_len());
        if ($urandom_range(2) == 0)
            write_reg(rlpe_pkg::CFG_ADDR_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      rlpe_pkg::LEN_W'($urandom));
    endtask

    // stimulus
    initial begin
        stim_row_t row;
        int        phase;
        int        n;
        len_reg[rlpe_pkg::REG_ONE_HIGH] = rlpe_pkg::ONE_HIGH_RST;
        len_reg[rlpe_pkg::REG_ONE_LOW] = rlpe_pkg::ONE_LOW_RST;
        len_reg[rlpe_pkg::REG_ZERO_HIGH] = rlpe_pkg::ZERO_HIGH_RST;
        len_reg[rlpe_pkg::REG_ZERO_LOW] = rlpe_pkg::ZERO_LOW_RST;
        len_reg[rlpe_pkg::REG_LATCH] = rlpe_pkg::LATCH_RST;

        // reset values, bit order and byte order
        directed_rows.push_back(px_known(8'h00, 8'h00, 8'h00, rlpe_pkg::ZERO_HIGH_RST,
                                         rlpe_pkg::ZERO_LOW_RST, rlpe_pkg::LATCH_RST));
        directed_rows.push_back(px_known(8'hFF, 8'hFF, 8'hFF, rlpe_pkg::ONE_HIGH_RST,
                                         rlpe_pkg::ONE_LOW_RST, rlpe_pkg::LATCH_RST));
        directed_rows.push_back(px(8'h80, 8'h01, 8'hA5));
        directed_rows.push_back(px(8'h00, 8'hFF, 8'h00));
        directed_rows.push_back(px(8'h01, 8'h80, 8'h7E));
        // extreme lengths
        directed_rows.push_back(wr(rlpe_pkg::REG_ONE_HIGH, LEN_MAX));
        directed_rows.push_back(wr(rlpe_pkg::REG_ONE_LOW, LEN_MIN));
        directed_rows.push_back(wr(rlpe_pkg::REG_ZERO_HIGH, LEN_MIN));
        directed_rows.push_back(wr(rlpe_pkg::REG_ZERO_LOW, LEN_MAX));
        directed_rows.push_back(wr(rlpe_pkg::REG_LATCH, LEN_MAX));
        directed_rows.push_back(px_known(8'hFF, 8'hFF, 8'hFF, LEN_MAX, LEN_MIN, LEN_MAX));
        directed_rows.push_back(px_known(8'h00, 8'h00, 8'h00, LEN_MIN, LEN_MAX, LEN_MAX));
        directed_rows.push_back(px(8'h3C, 8'hC3, 8'h5A));
        // zero length registers are used as written
        directed_rows.push_back(wr(rlpe_pkg::REG_ONE_HIGH, LEN_ZERO));
        directed_rows.push_back(wr(rlpe_pkg::REG_ONE_LOW, LEN_ZERO));
        directed_rows.push_back(wr(rlpe_pkg::REG_ZERO_HIGH, LEN_ZERO));
        directed_rows.push_back(wr(rlpe_pkg::REG_ZERO_LOW, LEN_ZERO));
        directed_rows.push_back(wr(rlpe_pkg::REG_LATCH, LEN_ZERO));
        directed_rows.push_back(px_known(8'hFF, 8'hFF, 8'hFF, LEN_ZERO, LEN_ZERO, LEN_ZERO));
        directed_rows.push_back(px_known(8'h00, 8'h00, 8'h00, LEN_ZERO, LEN_ZERO, LEN_ZERO));
        directed_rows.push_back(px(8'h96, 8'h69, 8'hF0));
        // distinct small lengths, then writes past the last register
        directed_rows.push_back(wr(rlpe_pkg::REG_ONE_HIGH, 16'd1));
        directed_rows.push_back(wr(rlpe_pkg::REG_ONE_LOW, 16'd2));
        directed_rows.push_back(wr(rlpe_pkg::REG_ZERO_HIGH, 16'd3));
        directed_rows.push_back(wr(rlpe_pkg::REG_ZERO_LOW, 16'd4));
        directed_rows.push_back(wr(rlpe_pkg::REG_LATCH, 16'd1));
        directed_rows.push_back(wr(REG_SPARE_FIRST, 16'h1234));
        directed_rows.push_back(wr(REG_SPARE_LAST, 16'hBEEF));
        directed_rows.push_back(px_known(8'hFF, 8'hFF, 8'hFF, 16'd1, 16'd2, 16'd1));
        directed_rows.push_back(px_known(8'h00, 8'h00, 8'h00, 16'd3, 16'd4, 16'd1));
        directed_rows.push_back(px(8'hA5, 8'h5A, 8'hC3));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_REG_WRITE) begin
                drain();
                write_reg(row.addr, row.value);
            end else begin
                sender_gap();
                send_pixel(row);
            end
        end

        // random phases: hold-off on the first, no idling on the third
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            randomize_regs();
            calm = (phase == 2);
            if (phase == 0) rx_hold_req = 1'b1;
            for (n = 0; n < PIXELS_PER_PHASE; n++) begin
                if (phase != 0 || n > 8) sender_gap();
                send_pixel(px(rand_byte(), rand_byte(), rand_byte()));
            end
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left = RX_HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 6);
            end
        end
    end

    // compare each output transaction with the oldest expected segment
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_segs.size() == 0) begin
                $error("unexpected segment: level %0d, length %0d, last %0d",
                       m_tdata[0], m_tdata[16:1], m_tlast);
                fail_cnt++;
            end else begin
                want = pending_segs.pop_front();
                if (m_tdata[0] !== want.level) begin
                    $error("line_level: expected %0d, got %0d", want.level, m_tdata[0]);
                    fail_cnt++;
                end
                if (m_tdata[16:1] !== want.len) begin
                    $error("seg_length: expected %0d, got %0d", want.len, m_tdata[16:1]);
                    fail_cnt++;
                end
                if (m_tlast !== want.last) begin
                    $error("final_segment: expected %0d, got %0d", want.last, m_tlast);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
